[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by sxfb_ctrl and sxfb_datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/sxfb_pkg.sv]
// ----------------------------------------------------------------------------
// sxfb_pkg
// types and constants of the sprite xor framebuffer
// ----------------------------------------------------------------------------
package sxfb_pkg;

    localparam int SPRITE_BITS = 8;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_SET   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_DRAW  = 2'd3
    } req_e;

    typedef struct packed {
        req_e                   req_type;
        logic [7:0]             x;
        logic [7:0]             y;
        logic [SPRITE_BITS-1:0] sprite_row;
        logic                   last_row;
    } req_item_t;

    typedef struct packed {
        logic pixel_value;
        logic collision;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_e;

    typedef struct packed {
        logic load;
        logic read;
        logic commit;
    } cmd_t;

endpackage

[hw/rtl/sxfb_ctrl.sv]
// ----------------------------------------------------------------------------
// sxfb_ctrl
// request sequencer: capture, row read, commit, and the response valid flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxfb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sxfb_pkg::cmd_t cmd
);
    import sxfb_pkg::*;

    state_e state_reg;
    state_e state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `ASSERT_NEXT(a_accept_reads, clk, rst_n, req_valid && req_ready, state_reg == ST_READ)
    `ASSERT_NEXT(a_read_then_exec, clk, rst_n, state_reg == ST_READ, state_reg == ST_EXEC)
    `ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, rsp_valid_reg)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, state_reg == ST_EXEC && !out_free, state_reg == ST_EXEC)

endmodule

[hw/rtl/sxfb_datapath.sv]
// ----------------------------------------------------------------------------
// sxfb_datapath
// row memory with per-row valid bits, pixel mask, sprite counter and result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxfb_datapath #(
    parameter int SCREEN_WIDTH    = 64,
    parameter int SCREEN_HEIGHT   = 32,
    parameter int MAX_SPRITE_ROWS = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sxfb_pkg::cmd_t      cmd,
    input  sxfb_pkg::req_item_t req,
    output sxfb_pkg::rsp_item_t rsp
);
    import sxfb_pkg::*;

    localparam int RowW = $clog2(SCREEN_HEIGHT);
    localparam int ColW = $clog2(SCREEN_WIDTH);
    localparam int CntW = $clog2(MAX_SPRITE_ROWS + 1);
    localparam int SumW = 16;
    localparam int Steps = 6;

    logic [SCREEN_WIDTH-1:0] mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] row_valid_reg;

    req_e                    req_type_reg;
    logic                    last_row_reg;
    logic [RowW-1:0]         row_idx_reg;
    logic [SCREEN_WIDTH-1:0] mask_reg;
    logic [SCREEN_WIDTH-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    rsp_item_t               rsp_reg;
    logic [CntW-1:0]         cnt_reg;
    logic [CntW-1:0]         cnt_next;
    logic                    acc_reg;
    logic                    acc_next;

    logic                    drawing;
    logic [SumW-1:0]         row_sum;
    logic [RowW-1:0]         row_idx;
    logic [ColW-1:0]         col_base;
    logic [ColW:0]           col_pos;
    logic [SCREEN_WIDTH-1:0] mask;
    logic [SCREEN_WIDTH-1:0] row_word;
    logic [SCREEN_WIDTH-1:0] wr_data;
    logic                    wr_en;
    logic                    hit;
    rsp_item_t               rsp_next;

    function automatic logic [RowW-1:0] wrap_row(input logic [SumW-1:0] v);
        logic [SumW-1:0] t;
        t = v;
        for (int k = Steps - 1; k >= 0; k--)
        begin
            if (t >= SumW'(SCREEN_HEIGHT << k))
            begin
                t = t - SumW'(SCREEN_HEIGHT << k);
            end
        end
        return t[RowW-1:0];
    endfunction

    function automatic logic [ColW-1:0] wrap_col(input logic [SumW-1:0] v);
        logic [SumW-1:0] t;
        t = v;
        for (int k = Steps - 1; k >= 0; k--)
        begin
            if (t >= SumW'(SCREEN_WIDTH << k))
            begin
                t = t - SumW'(SCREEN_WIDTH << k);
            end
        end
        return t[ColW-1:0];
    endfunction

    // request capture: wrapped row index and column mask
    assign drawing = (cnt_reg < CntW'(MAX_SPRITE_ROWS));

    always_comb
    begin
        col_pos = '0;
        mask    = '0;
        if (req.req_type == REQ_DRAW)
        begin
            row_sum = SumW'(req.y) + SumW'(cnt_reg);
        end
        else
        begin
            row_sum = SumW'(req.y);
        end
        row_idx  = wrap_row(row_sum);
        col_base = wrap_col(SumW'(req.x));
        if (req.req_type == REQ_DRAW)
        begin
            if (drawing)
            begin
                for (int k = 0; k < SPRITE_BITS; k++)
                begin
                    col_pos = (ColW+1)'(col_base) + (ColW+1)'(k);
                    if (col_pos >= (ColW+1)'(SCREEN_WIDTH))
                    begin
                        col_pos = col_pos - (ColW+1)'(SCREEN_WIDTH);
                    end
                    if (req.sprite_row[SPRITE_BITS-1-k])
                    begin
                        mask[col_pos[ColW-1:0]] = 1'b1;
                    end
                end
            end
        end
        else
        begin
            mask[col_base] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req.req_type;
            last_row_reg <= req.last_row;
            row_idx_reg  <= row_idx;
            mask_reg     <= mask;
        end
    end

    // commit: merge the mask into the row word (or for set, xor for draw) and form the response
    assign row_word = rd_valid_reg ? rd_data_reg : '0;
    assign hit      = |(row_word & mask_reg);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_data  = row_word;
        rsp_next = '0;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        case (req_type_reg)
            REQ_SET:
            begin
                wr_en   = 1'b1;
                wr_data = row_word | mask_reg;
            end
            REQ_QUERY:
            begin
                rsp_next.pixel_value = hit;
            end
            REQ_DRAW:
            begin
                wr_en              = 1'b1;
                wr_data            = row_word ^ mask_reg;
                rsp_next.collision = acc_reg | hit;
                if (drawing)
                begin
                    cnt_next = cnt_reg + CntW'(1);
                end
                acc_next = acc_reg | hit;
                if (last_row_reg)
                begin
                    cnt_next = '0;
                    acc_next = 1'b0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[row_idx_reg] <= wr_data;
        end
        if (cmd.read)
        begin
            rd_data_reg  <= mem[row_idx_reg];
            rd_valid_reg <= row_valid_reg[row_idx_reg];
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            cnt_reg       <= '0;
            acc_reg       <= 1'b0;
        end
        else if (cmd.commit)
        begin
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
            if (req_type_reg == REQ_CLEAR)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[row_idx_reg] <= 1'b1;
            end
        end
    end

    assign rsp = rsp_reg;

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CntW'(MAX_SPRITE_ROWS))
    `ASSERT_NEXT(a_last_clears, clk, rst_n, cmd.commit && req_type_reg == REQ_DRAW && last_row_reg, cnt_reg == '0 && acc_reg == 1'b0)
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.commit && req_type_reg == REQ_CLEAR, row_valid_reg == '0)

endmodule

[hw/rtl/sprite_xor_framebuffer_core.sv]
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_core
// monochrome framebuffer with clear, set, query and xor sprite-row draw
//
//   channel  signals                      payload
//   request  req_valid / req_ready / req  req_type, x, y, sprite_row, last_row
//   response rsp_valid / rsp_ready / rsp  pixel_value, collision
//
// an item runs through capture, row read and commit, all on one row port
// a new item is accepted only after the previous one has committed
// a commit waits while a previous response is still unread
// reset clears the per-row valid bits at once, so no clearing pass runs
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer_core #(
    parameter int SCREEN_WIDTH    = 64,
    parameter int SCREEN_HEIGHT   = 32,
    parameter int MAX_SPRITE_ROWS = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sxfb_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sxfb_pkg::rsp_item_t rsp
);
    import sxfb_pkg::*;

    cmd_t cmd;

    sxfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    sxfb_datapath #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .MAX_SPRITE_ROWS (MAX_SPRITE_ROWS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sprite_xor_framebuffer_core.
// It keeps a shadow copy of the 64x32 screen, the sprite row counter and the
// collision flag. Each accepted request item is applied to the copy, and the
// response it should cause is queued. Each response is then checked against
// the oldest queued one. The stimulus is a short directed part, then random
// sprites, redraws, overlong sprites, set/query/clear traffic and stray draws.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sxfb_pkg::*;

    localparam int W            = 64;
    localparam int H            = 32;
    localparam int MAX_ROWS     = 15;
    localparam int TOTAL_ITEMS  = 1825;
    localparam int STALL_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 20;

    class screen_tracker;
        bit [W-1:0] frame [H];
        int         rows_drawn;
        bit         hit;
        rsp_item_t  owed [$];
        int         mismatches;

        function int owed_count();
            return owed.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task note_request(req_item_t item);
            rsp_item_t due;
            int        row;
            int        col;
            int        k;
            due = '0;
            case (item.req_type)
                REQ_CLEAR: foreach (frame[i]) frame[i] = '0;
                REQ_SET:   frame[int'(item.y) % H][int'(item.x) % W] = 1'b1;
                REQ_QUERY: due.pixel_value = frame[int'(item.y) % H][int'(item.x) % W];
                default:
                begin
                    if (rows_drawn < MAX_ROWS)
                    begin
                        row = (int'(item.y) + rows_drawn) % H;
                        for (k = 0; k < SPRITE_BITS; k++)
                        begin
                            if (item.sprite_row[SPRITE_BITS-1-k])
                            begin
                                col = (int'(item.x) + k) % W;
                                if (frame[row][col])
                                    hit = 1'b1;
                                frame[row][col] = ~frame[row][col];
                            end
                        end
                        rows_drawn++;
                    end
                    due.collision = hit;
                    if (item.last_row)
                    begin
                        rows_drawn = 0;
                        hit        = 1'b0;
                    end
                end
            endcase
            owed.push_back(due);
        endtask

        task check_response(rsp_item_t got);
            rsp_item_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("response %b with none outstanding", got));
                return;
            end
            want = owed.pop_front();
            if (got.pixel_value !== want.pixel_value)
                report($sformatf("pixel_value %b, want %b", got.pixel_value, want.pixel_value));
            if (got.collision !== want.collision)
                report($sformatf("collision %b, want %b", got.collision, want.collision));
        endtask
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    screen_tracker tracker = new();
    bit            steady;
    int            sent;
    int            idle_cycles;

    sprite_xor_framebuffer_core #(
        .SCREEN_WIDTH    (W),
        .SCREEN_HEIGHT   (H),
        .MAX_SPRITE_ROWS (MAX_ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic req_item_t req_of(req_e kind, int x, int y, int bits, int last);
        req_item_t item;
        item.req_type   = kind;
        item.x          = x[7:0];
        item.y          = y[7:0];
        item.sprite_row = bits[SPRITE_BITS-1:0];
        item.last_row   = last[0];
        return item;
    endfunction

    function automatic req_item_t stray_req();
        req_e kind;
        kind = ($urandom_range(0, 24) == 0) ? REQ_CLEAR :
               ($urandom_range(0, 1) ? REQ_SET : REQ_QUERY);
        return req_of(kind, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 1));
    endfunction

    task automatic send_request(req_item_t item);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        tracker.note_request(item);
        sent++;
    endtask

    task automatic take_response();
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rsp_ready <= 1'b1;
        @(posedge clk);
        while (!rsp_valid) @(posedge clk);
        tracker.check_response(rsp);
    endtask

    initial
    begin
        @(posedge rst_n);
        forever take_response();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int pick;
        int i;
        int prev_x;
        int prev_y;
        int prev_n;
        int prev_bits [18];

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset state, wrapped set and query
        send_request(req_of(REQ_QUERY, 0, 0, 0, 0));
        send_request(req_of(REQ_SET, 255, 255, 0, 0));
        send_request(req_of(REQ_QUERY, 63, 31, 0, 0));
        send_request(req_of(REQ_QUERY, 127, 63, 255, 1));
        // one-row sprite erasing a lit pixel
        send_request(req_of(REQ_SET, 0, 0, 0, 0));
        send_request(req_of(REQ_DRAW, 0, 0, 'h80, 1));
        send_request(req_of(REQ_QUERY, 0, 0, 0, 0));
        // sprite wrapping both edges, query in between keeps the counter
        send_request(req_of(REQ_DRAW, 250, 31, 'hff, 0));
        send_request(req_of(REQ_QUERY, 63, 31, 0, 1));
        send_request(req_of(REQ_DRAW, 250, 31, 'hff, 1));
        send_request(req_of(REQ_DRAW, 0, 0, 'h00, 1));
        send_request(req_of(REQ_CLEAR, 0, 0, 0, 0));
        // overlong sprite: the row past the limit is dropped but still ends it
        for (i = 0; i < MAX_ROWS; i++)
            send_request(req_of(REQ_DRAW, 60, 20, (i % 2) ? 'hff : 'hc3, 0));
        send_request(req_of(REQ_DRAW, 60, 20, 'hff, 1));
        send_request(req_of(REQ_QUERY, 60, 3, 0, 0));

        prev_x = 0;
        prev_y = 0;
        prev_n = 0;
        while (sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
                steady = ~steady;
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // a new sprite, or a redraw of the previous one to erase it
                if (!(pick < 15 && prev_n > 0))
                begin
                    prev_x = $urandom_range(0, 255);
                    prev_y = $urandom_range(0, 255);
                    prev_n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
                                                          : $urandom_range(1, 6);
                    for (i = 0; i < prev_n; i++)
                        prev_bits[i] = $urandom_range(0, 255);
                end
                for (i = 0; i < prev_n; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(stray_req());
                    send_request(req_of(REQ_DRAW, prev_x, prev_y, prev_bits[i],
                                        int'(i == prev_n - 1)));
                end
            end
            else if (pick < 70)
                send_request(req_of(REQ_DRAW, $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 1)));
            else if (pick < 85)
                send_request(req_of(REQ_QUERY, prev_x + $urandom_range(0, 7),
                                    prev_y + $urandom_range(0, 15),
                                    $urandom_range(0, 255), $urandom_range(0, 1)));
            else
                send_request(stray_req());
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (tracker.owed_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.owed_count() != 0)
            tracker.report($sformatf("%0d responses never arrived", tracker.owed_count()));
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[sprite_xor_framebuffer_core.f]
+incdir+hw/rtl
hw/rtl/sxfb_pkg.sv
hw/rtl/sxfb_ctrl.sv
hw/rtl/sxfb_datapath.sv
hw/rtl/sprite_xor_framebuffer_core.sv
dv/tb.sv
